// File: src/pfa_pkg.sv
// Shared constants and codes for the page frame allocator.
// No dependencies; imported by the core and the testbench.
package pfa_pkg;

  localparam int NUM_PAGES   = 4096;
  localparam int LOW_PAGES   = 1024;
  localparam int STACK_DEPTH = NUM_PAGES - LOW_PAGES;

  localparam int PAGE_W  = 12;
  localparam int CNT_W   = 11;
  localparam int REF_W   = 16;
  localparam int TOTAL_W = 13;
  localparam int FILL_W  = 12;

  localparam logic [REF_W-1:0] REF_MAX = 16'hFFFF;

  localparam logic [2:0] ACT_ALLOC_ONE    = 3'd0;
  localparam logic [2:0] ACT_ALLOC_CONTIG = 3'd1;
  localparam logic [2:0] ACT_FREE         = 3'd2;
  localparam logic [2:0] ACT_REF_INC      = 3'd3;
  localparam logic [2:0] ACT_INIT_FREE    = 3'd4;
  localparam logic [2:0] ACT_INIT_RESERVE = 3'd5;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_OOM     = 2'd1;
  localparam logic [1:0] ST_REFUSED = 2'd2;
  localparam logic [1:0] ST_UNREF   = 2'd3;

endpackage

// File: src/pfa_ram.sv
// Generic single-clock RAM: one write port, one read port, registered read.
// No dependencies.
module pfa_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: src/page_frame_allocator_refcount_core.sv
// Page frame allocator core: reference count RAM, free stack RAM, sequencer.
// Depends on pfa_pkg and pfa_ram.
// Each range page touched is a ref RAM read, then a modify/write;
// alloc_one pops the free stack, or else scans the counts of the 1024 low pages;
// alloc_contig reads and checks each probed page, then marks the run it found;
// init_reserve of a stacked page also scans the stack for it and shifts entries down.
// One request at a time. After reset a pass over all 4096 pages sets every count to 65535.
module page_frame_allocator_refcount_core
  import pfa_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [2:0]         action,
  input  logic [PAGE_W-1:0]  page_number,
  input  logic [CNT_W-1:0]   page_count,
  input  logic [CNT_W-1:0]   search_limit,
  input  logic [CNT_W-1:0]   alignment,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [1:0]         status,
  output logic [PAGE_W-1:0]  result_page,
  output logic [REF_W-1:0]   ref_value,
  output logic [TOTAL_W-1:0] available_pages
);

  localparam logic [4:0] S_CLR      = 5'd0;
  localparam logic [4:0] S_IDLE     = 5'd1;
  localparam logic [4:0] S_START    = 5'd2;
  localparam logic [4:0] S_POP_WAIT = 5'd3;
  localparam logic [4:0] S_SCAN_RD  = 5'd4;
  localparam logic [4:0] S_SCAN_CHK = 5'd5;
  localparam logic [4:0] S_CS_RD    = 5'd6;
  localparam logic [4:0] S_CS_CHK   = 5'd7;
  localparam logic [4:0] S_CS_WR    = 5'd8;
  localparam logic [4:0] S_RNG_RD   = 5'd9;
  localparam logic [4:0] S_RNG_PROC = 5'd10;
  localparam logic [4:0] S_FIRST_RD = 5'd11;
  localparam logic [4:0] S_FIRST_WT = 5'd12;
  localparam logic [4:0] S_WD_RD    = 5'd13;
  localparam logic [4:0] S_WD_CHK   = 5'd14;
  localparam logic [4:0] S_SH_RD    = 5'd15;
  localparam logic [4:0] S_SH_WR    = 5'd16;
  localparam logic [4:0] S_DONE     = 5'd17;

  logic [4:0]         state, state_next;
  logic [PAGE_W-1:0]  clr, clr_next;
  logic [2:0]         act;
  logic [PAGE_W-1:0]  first;
  logic [CNT_W-1:0]   n, lim, lim_next, algn, algn_next;
  logic [CNT_W-1:0]   m, m_next;
  logic [FILL_W-1:0]  k, k_next;
  logic [PAGE_W-1:0]  s, s_next;
  logic               phase, phase_next;
  logic [1:0]         st, st_next;
  logic [PAGE_W-1:0]  got, got_next;
  logic [REF_W-1:0]   rv, rv_next;
  logic [TOTAL_W-1:0] free_total, free_next;
  logic [FILL_W-1:0]  fill, fill_next;

  logic               ref_we, ref_re;
  logic [PAGE_W-1:0]  ref_waddr, ref_raddr;
  logic [REF_W-1:0]   ref_wdata, ref_rdata;
  logic               stk_we, stk_re;
  logic [FILL_W-1:0]  stk_waddr, stk_raddr;
  logic [PAGE_W-1:0]  stk_wdata, stk_rdata;

  logic [TOTAL_W-1:0] pg;
  logic               pg_low, rel, accept, load_out;
  logic [TOTAL_W-1:0] s_end;

  pfa_ram #(.WIDTH(REF_W), .DEPTH(NUM_PAGES)) u_ref_ram (
    .clk(clk), .we(ref_we), .waddr(ref_waddr), .wdata(ref_wdata),
    .re(ref_re), .raddr(ref_raddr), .rdata(ref_rdata)
  );

  pfa_ram #(.WIDTH(PAGE_W), .DEPTH(STACK_DEPTH)) u_stack_ram (
    .clk(clk), .we(stk_we), .waddr(stk_waddr), .wdata(stk_wdata),
    .re(stk_re), .raddr(stk_raddr), .rdata(stk_rdata)
  );

  assign in_ready = (state == S_IDLE);
  assign accept   = in_valid && in_ready;
  assign load_out = (state == S_DONE) && (!out_valid || out_ready);
  assign pg       = {1'b0, first} + {2'b0, m};
  assign pg_low   = pg < TOTAL_W'(LOW_PAGES);
  assign s_end    = {1'b0, s} + {2'b0, n};

  always_comb begin
    state_next = state;
    clr_next   = clr;
    lim_next   = lim;
    algn_next  = algn;
    m_next     = m;
    k_next     = k;
    s_next     = s;
    phase_next = phase;
    st_next    = st;
    got_next   = got;
    rv_next    = rv;
    free_next  = free_total;
    fill_next  = fill;
    ref_we     = 1'b0;
    ref_re     = 1'b0;
    ref_waddr  = pg[PAGE_W-1:0];
    ref_raddr  = pg[PAGE_W-1:0];
    ref_wdata  = '0;
    stk_we     = 1'b0;
    stk_re     = 1'b0;
    stk_waddr  = fill;
    stk_raddr  = k;
    stk_wdata  = pg[PAGE_W-1:0];
    rel        = 1'b0;

    case (state)
      S_CLR: begin
        ref_we    = 1'b1;
        ref_waddr = clr;
        ref_wdata = REF_MAX;
        clr_next  = clr + PAGE_W'(1);
        if (clr == PAGE_W'(NUM_PAGES - 1)) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        if (accept) begin
          state_next = S_START;
          st_next    = ST_OK;
          got_next   = '0;
          rv_next    = '0;
          m_next     = '0;
          k_next     = '0;
          s_next     = '0;
          phase_next = 1'b0;
          lim_next   = search_limit;
          algn_next  = alignment;
        end
      end
      S_START: begin
        case (act)
          ACT_ALLOC_ONE: begin
            if (fill != '0) begin
              stk_re     = 1'b1;
              stk_raddr  = fill - FILL_W'(1);
              state_next = S_POP_WAIT;
            end else begin
              state_next = S_SCAN_RD;
            end
          end
          ACT_ALLOC_CONTIG: begin
            if (lim > CNT_W'(LOW_PAGES)) begin
              lim_next = CNT_W'(LOW_PAGES);
            end
            if (algn == '0) begin
              algn_next = CNT_W'(1);
            end
            if (n == '0) begin
              st_next    = ST_OOM;
              state_next = S_DONE;
            end else begin
              state_next = S_CS_RD;
            end
          end
          ACT_FREE, ACT_REF_INC, ACT_INIT_FREE, ACT_INIT_RESERVE: begin
            state_next = S_RNG_RD;
          end
          default: state_next = S_DONE;
        endcase
      end
      S_POP_WAIT: begin
        got_next   = stk_rdata;
        ref_we     = 1'b1;
        ref_waddr  = stk_rdata;
        ref_wdata  = REF_W'(1);
        fill_next  = fill - FILL_W'(1);
        free_next  = free_total - TOTAL_W'(1);
        state_next = S_DONE;
      end
      S_SCAN_RD: begin
        ref_re     = 1'b1;
        ref_raddr  = k;
        state_next = S_SCAN_CHK;
      end
      S_SCAN_CHK: begin
        if (ref_rdata == '0) begin
          ref_we     = 1'b1;
          ref_waddr  = k;
          ref_wdata  = REF_W'(1);
          got_next   = k;
          free_next  = free_total - TOTAL_W'(1);
          state_next = S_DONE;
        end else if (k == FILL_W'(LOW_PAGES - 1)) begin
          st_next    = ST_OOM;
          state_next = S_DONE;
        end else begin
          k_next     = k + FILL_W'(1);
          state_next = S_SCAN_RD;
        end
      end
      S_CS_RD: begin
        if (m == n) begin
          got_next   = s;
          m_next     = '0;
          state_next = S_CS_WR;
        end else if (s_end > {2'b0, lim}) begin
          st_next    = ST_OOM;
          state_next = S_DONE;
        end else begin
          ref_re     = 1'b1;
          ref_raddr  = s + {1'b0, m};
          state_next = S_CS_CHK;
        end
      end
      S_CS_CHK: begin
        if (ref_rdata == '0) begin
          m_next = m + CNT_W'(1);
        end else begin
          s_next = s + {1'b0, algn};
          m_next = '0;
        end
        state_next = S_CS_RD;
      end
      S_CS_WR: begin
        if (m == n) begin
          free_next  = free_total - {2'b0, n};
          state_next = S_DONE;
        end else begin
          ref_we    = 1'b1;
          ref_waddr = got + {1'b0, m};
          ref_wdata = REF_W'(1);
          m_next    = m + CNT_W'(1);
        end
      end
      S_RNG_RD: begin
        if (m >= n) begin
          if (act == ACT_REF_INC && !phase) begin
            m_next     = '0;
            phase_next = 1'b1;
            state_next = (n == '0) ? S_FIRST_RD : S_RNG_RD;
          end else begin
            state_next = S_DONE;
          end
        end else if (pg >= TOTAL_W'(NUM_PAGES)) begin
          // range ran off the end; ref_inc refuses, others stop
          if (act == ACT_REF_INC) begin
            st_next = ST_REFUSED;
          end
          state_next = S_DONE;
        end else begin
          ref_re     = 1'b1;
          state_next = S_RNG_PROC;
        end
      end
      S_RNG_PROC: begin
        m_next     = m + CNT_W'(1);
        state_next = S_RNG_RD;
        case (act)
          ACT_FREE: begin
            if (ref_rdata == '0) begin
              st_next = ST_UNREF;
            end else begin
              ref_we    = 1'b1;
              ref_wdata = ref_rdata - REF_W'(1);
              rel       = (ref_rdata == REF_W'(1));
            end
          end
          ACT_REF_INC: begin
            if (!phase) begin
              if (ref_rdata == '0 || ref_rdata == REF_MAX) begin
                st_next    = ST_REFUSED;
                state_next = S_DONE;
              end
            end else begin
              ref_we    = 1'b1;
              ref_wdata = ref_rdata + REF_W'(1);
              if (m == '0) begin
                rv_next = ref_rdata + REF_W'(1);
              end
            end
          end
          ACT_INIT_FREE: begin
            if (ref_rdata != '0) begin
              ref_we    = 1'b1;
              ref_wdata = '0;
              rel       = 1'b1;
            end
          end
          ACT_INIT_RESERVE: begin
            ref_we    = 1'b1;
            ref_wdata = REF_MAX;
            if (ref_rdata == '0) begin
              if (pg_low) begin
                free_next = free_total - TOTAL_W'(1);
              end else if (fill != '0) begin
                // hold m; withdraw the page from the stack first
                m_next     = m;
                k_next     = '0;
                state_next = S_WD_RD;
              end
            end
          end
          default: ;
        endcase
      end
      S_FIRST_RD: begin
        ref_re     = 1'b1;
        ref_raddr  = first;
        state_next = S_FIRST_WT;
      end
      S_FIRST_WT: begin
        rv_next    = ref_rdata;
        state_next = S_DONE;
      end
      S_WD_RD: begin
        stk_re     = 1'b1;
        state_next = S_WD_CHK;
      end
      S_WD_CHK: begin
        if (stk_rdata == pg[PAGE_W-1:0]) begin
          if (k + FILL_W'(1) < fill) begin
            state_next = S_SH_RD;
          end else begin
            fill_next  = fill - FILL_W'(1);
            free_next  = free_total - TOTAL_W'(1);
            m_next     = m + CNT_W'(1);
            state_next = S_RNG_RD;
          end
        end else if (k + FILL_W'(1) >= fill) begin
          m_next     = m + CNT_W'(1);
          state_next = S_RNG_RD;
        end else begin
          k_next     = k + FILL_W'(1);
          state_next = S_WD_RD;
        end
      end
      S_SH_RD: begin
        stk_re     = 1'b1;
        stk_raddr  = k + FILL_W'(1);
        state_next = S_SH_WR;
      end
      S_SH_WR: begin
        stk_we    = 1'b1;
        stk_waddr = k;
        stk_wdata = stk_rdata;
        k_next    = k + FILL_W'(1);
        if (k + FILL_W'(2) < fill) begin
          state_next = S_SH_RD;
        end else begin
          fill_next  = fill - FILL_W'(1);
          free_next  = free_total - TOTAL_W'(1);
          m_next     = m + CNT_W'(1);
          state_next = S_RNG_RD;
        end
      end
      S_DONE: begin
        if (load_out) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase

    // page reached zero: low pages are free by their count alone
    if (rel) begin
      if (pg_low) begin
        free_next = free_total + TOTAL_W'(1);
      end else if (fill < FILL_W'(STACK_DEPTH)) begin
        stk_we    = 1'b1;
        stk_waddr = fill;
        stk_wdata = pg[PAGE_W-1:0];
        fill_next = fill + FILL_W'(1);
        free_next = free_total + TOTAL_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_CLR;
      clr        <= '0;
      free_total <= '0;
      fill       <= '0;
      out_valid  <= 1'b0;
    end else begin
      state      <= state_next;
      clr        <= clr_next;
      free_total <= free_next;
      fill       <= fill_next;
      if (load_out) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      act   <= action;
      first <= page_number;
      n     <= page_count;
    end
    lim   <= lim_next;
    algn  <= algn_next;
    m     <= m_next;
    k     <= k_next;
    s     <= s_next;
    phase <= phase_next;
    st    <= st_next;
    got   <= got_next;
    rv    <= rv_next;
    if (load_out) begin
      status          <= st;
      result_page     <= got;
      ref_value       <= rv;
      available_pages <= free_total;
    end
  end

endmodule

// File: tb/tb_top.sv
// Self-checking testbench for page_frame_allocator_refcount_core.
// Depends on pfa_pkg and the core; a directed table, then weighted random requests, checked
// against typed expectations or an in-bench allocator predictor, with random stalls on both ports.
`timescale 1ns / 1ps

module tb_top;
  import pfa_pkg::*;

  typedef struct {
    logic [2:0]         act;
    logic [PAGE_W-1:0]  pg;
    logic [CNT_W-1:0]   cnt;
    logic [CNT_W-1:0]   lim;
    logic [CNT_W-1:0]   algn;
  } req_t;

  typedef struct {
    logic [1:0]         st;
    logic [PAGE_W-1:0]  page;
    logic [REF_W-1:0]   refv;
    logic [TOTAL_W-1:0] avail;
  } resp_t;

  typedef struct {
    req_t  rq;
    bit    typed;
    resp_t rs;
  } dir_row_t;

  localparam int RAND_ITEMS = 1650;
  localparam int QUIET_TAIL = 150;

  logic clk = 0;
  logic rst = 1;
  logic in_valid = 0;
  logic in_ready;
  logic [2:0] action = '0;
  logic [PAGE_W-1:0] page_number = '0;
  logic [CNT_W-1:0] page_count = '0;
  logic [CNT_W-1:0] search_limit = '0;
  logic [CNT_W-1:0] alignment = '0;
  logic out_valid;
  logic out_ready = 0;
  logic [1:0] status;
  logic [PAGE_W-1:0] result_page;
  logic [REF_W-1:0] ref_value;
  logic [TOTAL_W-1:0] available_pages;

  page_frame_allocator_refcount_core i_dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .action(action), .page_number(page_number), .page_count(page_count),
    .search_limit(search_limit), .alignment(alignment),
    .out_valid(out_valid), .out_ready(out_ready),
    .status(status), .result_page(result_page), .ref_value(ref_value),
    .available_pages(available_pages)
  );

  always #5 clk = ~clk;

  // predictor state
  logic [REF_W-1:0] page_refs [NUM_PAGES];
  bit               low_used [LOW_PAGES];
  int               free_stack [$];
  int               free_pages;

  resp_t expected_resps [$];
  int    held_pages [$];
  int    errors = 0;
  int    checked = 0;
  int    act_seen [8];
  bit    quiet = 0;
  int    stall_left = 0;

  function automatic void release_page(int p);
    if (p < LOW_PAGES) begin
      low_used[p] = 0;
    end else begin
      if (free_stack.size() >= STACK_DEPTH) return;
      free_stack.push_back(p);
    end
    free_pages++;
  endfunction

  function automatic void withdraw_page(int p);
    if (p < LOW_PAGES) begin
      low_used[p] = 1;
      free_pages--;
      return;
    end
    foreach (free_stack[k]) begin
      if (free_stack[k] == p) begin
        free_stack.delete(k);
        free_pages--;
        return;
      end
    end
  endfunction

  function automatic resp_t predict_alloc(req_t r);
    resp_t e;
    int n, lim, al, got, m, p;
    bit found, ok;
    e = '{ST_OK, '0, '0, '0};
    n = int'(r.cnt);
    got = 0;
    found = 0;
    case (r.act)
      ACT_ALLOC_ONE: begin
        if (free_stack.size() > 0) begin
          got = free_stack.pop_back();
          found = 1;
        end else begin
          for (int k = 0; k < LOW_PAGES; k++) begin
            if (!low_used[k]) begin
              low_used[k] = 1;
              got = k;
              found = 1;
              break;
            end
          end
        end
        if (found) begin
          page_refs[got] = REF_W'(1);
          free_pages--;
        end else begin
          e.st = ST_OOM;
          got = 0;
        end
      end
      ACT_ALLOC_CONTIG: begin
        lim = (int'(r.lim) > LOW_PAGES) ? LOW_PAGES : int'(r.lim);
        al = (r.algn == 0) ? 1 : int'(r.algn);
        if (n > 0) begin
          for (int s = 0; s + n <= lim; s += al) begin
            m = 0;
            while (m < n && !low_used[s+m]) m++;
            if (m == n) begin
              got = s;
              found = 1;
              break;
            end
          end
        end
        if (found) begin
          for (int k = 0; k < n; k++) begin
            low_used[got+k] = 1;
            page_refs[got+k] = REF_W'(1);
          end
          free_pages -= n;
        end else begin
          e.st = ST_OOM;
          got = 0;
        end
      end
      ACT_FREE: begin
        for (int k = 0; k < n; k++) begin
          p = int'(r.pg) + k;
          if (p >= NUM_PAGES) continue;
          if (page_refs[p] == 0) begin
            e.st = ST_UNREF;
            continue;
          end
          page_refs[p]--;
          if (page_refs[p] == 0) release_page(p);
        end
      end
      ACT_REF_INC: begin
        ok = 1;
        for (int k = 0; ok && k < n; k++) begin
          p = int'(r.pg) + k;
          if (p >= NUM_PAGES || page_refs[p] == 0 || page_refs[p] == REF_MAX) ok = 0;
        end
        if (ok) begin
          for (int k = 0; k < n; k++) page_refs[int'(r.pg)+k]++;
          e.refv = page_refs[r.pg];
        end else begin
          e.st = ST_REFUSED;
        end
      end
      ACT_INIT_FREE, ACT_INIT_RESERVE: begin
        for (int k = 0; k < n; k++) begin
          p = int'(r.pg) + k;
          if (p >= NUM_PAGES) continue;
          if (r.act == ACT_INIT_FREE) begin
            if (page_refs[p] != 0) begin
              page_refs[p] = '0;
              release_page(p);
            end
          end else begin
            if (page_refs[p] == 0) withdraw_page(p);
            page_refs[p] = REF_MAX;
          end
        end
      end
      default: ;
    endcase
    e.page = PAGE_W'(got);
    e.avail = TOTAL_W'(free_pages);
    if (e.st == ST_OK && (r.act == ACT_ALLOC_ONE || r.act == ACT_ALLOC_CONTIG))
      held_pages.push_back(got);
    return e;
  endfunction

  task automatic send_request(req_t r, bit typed, resp_t typed_rs);
    resp_t e;
    @(negedge clk);
    if (!quiet && $urandom_range(0, 3) == 0) begin
      in_valid <= 0;
      repeat ($urandom_range(1, 5)) @(negedge clk);
    end
    action <= r.act;
    page_number <= r.pg;
    page_count <= r.cnt;
    search_limit <= r.lim;
    alignment <= r.algn;
    in_valid <= 1;
    do @(posedge clk); while (!in_ready);
    e = predict_alloc(r);
    act_seen[r.act]++;
    expected_resps.push_back(typed ? typed_rs : e);
  endtask

  // receive side stalls in bursts
  always @(negedge clk) begin
    if (quiet) begin
      out_ready <= 1;
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_ready <= 0;
    end else if ($urandom_range(0, 4) == 0) begin
      stall_left <= $urandom_range(0, 4);
      out_ready <= 0;
    end else begin
      out_ready <= 1;
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      resp_t e;
      if (expected_resps.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected response: st=%0d page=%0d ref=%0d avail=%0d",
                                   status, result_page, ref_value, available_pages);
      end else begin
        e = expected_resps.pop_front();
        checked++;
        if (status !== e.st || result_page !== e.page || ref_value !== e.refv ||
            available_pages !== e.avail) begin
          errors++;
          if (errors <= 10)
            $display("mismatch #%0d: exp st=%0d page=%0d ref=%0d avail=%0d, got st=%0d page=%0d ref=%0d avail=%0d",
                     checked, e.st, e.page, e.refv, e.avail,
                     status, result_page, ref_value, available_pages);
        end
      end
    end
  end

  function automatic dir_row_t row(logic [2:0] a, int pg, int n, int lim, int al,
                                   bit typed = 0, logic [1:0] st = ST_OK,
                                   int rv = 0, int av = 0);
    dir_row_t d;
    d.rq = '{a, PAGE_W'(pg), CNT_W'(n), CNT_W'(lim), CNT_W'(al)};
    d.typed = typed;
    d.rs = '{st, '0, REF_W'(rv), TOTAL_W'(av)};
    return d;
  endfunction

  initial begin
    dir_row_t dir [$];
    req_t r;
    int pick, sel, wait_cnt;

    foreach (page_refs[k]) page_refs[k] = REF_MAX;
    foreach (low_used[k]) low_used[k] = 1;
    free_pages = 0;

    // nothing free after reset
    dir.push_back(row(ACT_ALLOC_ONE,    0, 0, 0, 0, 1, ST_OOM));
    dir.push_back(row(ACT_ALLOC_CONTIG, 0, 1, 1024, 1, 1, ST_OOM));
    dir.push_back(row(ACT_ALLOC_CONTIG, 0, 0, 1024, 1, 1, ST_OOM));
    // reserved page drops to 65534, bumps back, then refuses at the ceiling
    dir.push_back(row(ACT_FREE,         0, 1, 0, 0, 1, ST_OK));
    dir.push_back(row(ACT_REF_INC,      0, 1, 0, 0, 1, ST_OK, 65535));
    dir.push_back(row(ACT_REF_INC,      0, 1, 0, 0, 1, ST_REFUSED));
    dir.push_back(row(ACT_REF_INC,   4095, 2, 0, 0, 1, ST_REFUSED));
    dir.push_back(row(ACT_REF_INC,      5, 0, 0, 0, 1, ST_OK, 65535));
    dir.push_back(row(ACT_INIT_FREE,    0, 1024, 0, 0, 1, ST_OK, 0, 1024));
    dir.push_back(row(ACT_INIT_FREE, 4095, 2047, 0, 0, 1, ST_OK, 0, 1025));
    dir.push_back(row(ACT_INIT_FREE, 3000, 40, 0, 0));
    dir.push_back(row(ACT_FREE,         0, 1, 0, 0));
    dir.push_back(row(ACT_ALLOC_ONE,    0, 0, 0, 0));
    dir.push_back(row(ACT_ALLOC_CONTIG, 0, 8, 2047, 1024));
    dir.push_back(row(ACT_ALLOC_CONTIG, 0, 1024, 1024, 0));
    dir.push_back(row(ACT_INIT_RESERVE, 3010, 5, 0, 0));
    dir.push_back(row(ACT_INIT_RESERVE, 100, 2, 0, 0));
    dir.push_back(row(ACT_FREE,      4095, 1024, 0, 0));
    dir.push_back(row(ACT_FREE,         1, 1, 0, 0));
    dir.push_back(row(ACT_REF_INC,      2, 6, 0, 0));
    dir.push_back(row(3'd6,          4095, 2047, 2047, 2047));
    dir.push_back(row(3'd7,          4095, 2047, 2047, 2047));
    dir.push_back(row(ACT_FREE,      3500, 2047, 0, 0));
    dir.push_back(row(ACT_INIT_FREE,  500, 0, 0, 0));
    dir.push_back(row(ACT_INIT_RESERVE, 500, 0, 0, 0));

    repeat (3) @(posedge clk);
    @(negedge clk) rst <= 0;

    foreach (dir[i]) send_request(dir[i].rq, dir[i].typed, dir[i].rs);

    for (int i = 0; i < RAND_ITEMS; i++) begin
      if (i == RAND_ITEMS - QUIET_TAIL) quiet = 1;
      r = '{ACT_ALLOC_ONE, '0, '0, '0, '0};
      sel = $urandom_range(0, 99);
      if (sel < 24) begin
        r.act = ACT_ALLOC_ONE;
        r.pg = PAGE_W'($urandom);
      end else if (sel < 39) begin
        r.act = ACT_ALLOC_CONTIG;
        r.cnt = CNT_W'($urandom_range(1, 16));
        r.lim = ($urandom_range(0, 3) == 0) ? CNT_W'($urandom_range(0, 2047)) : CNT_W'(1024);
        case ($urandom_range(0, 3))
          0: r.algn = '0;
          1: r.algn = CNT_W'(1);
          2: r.algn = CNT_W'(1 << $urandom_range(1, 4));
          default: r.algn = CNT_W'($urandom_range(0, 2047));
        endcase
      end else if (sel < 77) begin
        r.act = (sel < 62) ? ACT_FREE : ACT_REF_INC;
        r.cnt = ($urandom_range(0, 4) == 0) ? CNT_W'($urandom_range(0, 4)) : CNT_W'(1);
        if (held_pages.size() > 0) begin
          pick = $urandom_range(0, held_pages.size() - 1);
          r.pg = PAGE_W'(held_pages[pick]);
          if (r.act == ACT_FREE && page_refs[r.pg] <= 1) held_pages.delete(pick);
        end else begin
          r.pg = PAGE_W'($urandom);
        end
      end else if (sel < 86) begin
        r.act = ACT_INIT_FREE;
        r.pg = ($urandom_range(0, 1) == 0) ? PAGE_W'($urandom_range(0, 1023))
                                           : PAGE_W'($urandom);
        r.cnt = CNT_W'($urandom_range(1, 24));
      end else if (sel < 93) begin
        r.act = ACT_INIT_RESERVE;
        r.pg = PAGE_W'($urandom);
        r.cnt = CNT_W'($urandom_range(0, 12));
      end else begin
        // junk: any action, any page, short ranges
        r.act = 3'($urandom_range(0, 7));
        r.pg = PAGE_W'($urandom);
        r.cnt = CNT_W'($urandom_range(0, 40));
        r.lim = CNT_W'($urandom);
        r.algn = CNT_W'($urandom);
      end
      send_request(r, 0, '{ST_OK, '0, '0, '0});
    end

    @(negedge clk) in_valid <= 0;
    wait (expected_resps.size() == 0);
    wait_cnt = 0;
    while (wait_cnt < 200) begin
      @(posedge clk);
      wait_cnt++;
    end

    $display("Ran %0d requests (alloc_one %0d, contig %0d, free %0d, ref_inc %0d,",
             checked, act_seen[0], act_seen[1], act_seen[2], act_seen[3]);
    $display("  init_free %0d, init_reserve %0d, unknown %0d); %0d mismatching",
             act_seen[4], act_seen[5], act_seen[6] + act_seen[7], errors);
    if (errors == 0 && expected_resps.size() == 0)
      $display("No mismatches found");
    else
      $display("Mismatches found");
    $finish;
  end

  initial begin
    #1_000_000_000;
    $display("Timeout with %0d responses outstanding", expected_resps.size());
    $display("Mismatches found");
    $finish;
  end

endmodule

// File: filelist.f
src/pfa_pkg.sv
src/pfa_ram.sv
src/page_frame_allocator_refcount_core.sv
tb/tb_top.sv
